### src/jmsv_pkg.sv
// ----------------------------------------------------------------------------
// jmsv_pkg
// Shared types and constants of the JPEG marker stream validator.
// ----------------------------------------------------------------------------
package jmsv_pkg;

  // marker bytes
  localparam logic [7:0] MK_PREFIX  = 8'hff;
  localparam logic [7:0] MK_SOI     = 8'hd8;
  localparam logic [7:0] MK_EOI     = 8'hd9;
  localparam logic [7:0] MK_RST_LO  = 8'hd0;
  localparam logic [7:0] MK_RST_HI  = 8'hd7;
  localparam logic [7:0] MK_SOS     = 8'hda;
  localparam logic [7:0] MK_SOF0    = 8'hc0;
  localparam logic [7:0] MK_TEM     = 8'h01;
  localparam logic [7:0] MK_STUFF   = 8'h00;

  // fixed segment layout
  localparam logic [15:0] SOS_HDR_LEN   = 16'd6;
  localparam logic [15:0] SOF_HDR_LEN   = 16'd8;
  localparam logic [15:0] MIN_SEG_LEN   = 16'd2;
  localparam logic [7:0]  BASE_PREC     = 8'd8;

  // configuration registers
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_HEIGHT = 1'b1;
  localparam logic [15:0] RST_EXP_WIDTH  = 16'd800;
  localparam logic [15:0] RST_EXP_HEIGHT = 16'd480;

  // verdict codes
  typedef enum logic [1:0] {
    V_OK          = 2'd0,
    V_INVALID     = 2'd1,
    V_UNSUPPORTED = 2'd2,
    V_SIZE        = 2'd3
  } verdict_t;

  // one step of the parser: a verdict or nothing
  typedef struct packed {
    logic     fire;
    verdict_t code;
  } jmsv_result_t;

endpackage

### src/jmsv_if.sv
// ----------------------------------------------------------------------------
// jmsv_if
// Valid/ready channels of the validator: byte stream in, verdicts out.
// ----------------------------------------------------------------------------
interface jmsv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface jmsv_verdict_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

### src/jmsv_parser.sv
// ----------------------------------------------------------------------------
// jmsv_parser
// Marker segment walker: state registers plus the single-byte step logic.
// ----------------------------------------------------------------------------
module jmsv_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  input  logic [15:0]          exp_width,
  input  logic [15:0]          exp_height,
  output jmsv_pkg::jmsv_result_t result
);
  import jmsv_pkg::*;

  typedef enum logic [2:0] {
    PH_SOI0, PH_SOI1, PH_MARK, PH_FILL, PH_LENH, PH_LENL, PH_BODY
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] size_r, size_nxt;
  logic [7:0]  marker_r, marker_nxt;
  logic        seen_r, seen_nxt;
  logic [7:0]  prec_r, prec_nxt;
  logic [15:0] height_r, height_nxt;
  logic [15:0] width_r, width_nxt;
  logic [7:0]  comp_r, comp_nxt;
  logic        given_r, given_nxt;

  jmsv_result_t step_res;
  jmsv_result_t jres;
  logic [16:0]  cnt_inc;
  logic [15:0]  len_full;

  function automatic logic is_frame(input logic [7:0] mk);
    return mk inside {[8'hc0:8'hc3], [8'hc5:8'hc7], [8'hc9:8'hcb], [8'hcd:8'hcf]};
  endfunction

  // judge a finished segment; fire low means carry on with the next marker
  function automatic jmsv_result_t judge(
    input logic [7:0]  mk,
    input logic [15:0] len,
    input logic        seen,
    input logic [7:0]  prec,
    input logic [15:0] h,
    input logic [15:0] w,
    input logic [7:0]  comp,
    input logic [15:0] ew,
    input logic [15:0] eh
  );
    logic [16:0]  sos_len;
    logic [16:0]  sof_len;
    jmsv_result_t r;
    sos_len = {1'b0, SOS_HDR_LEN} + {8'b0, comp, 1'b0};
    sof_len = {1'b0, SOF_HDR_LEN} + {9'b0, comp} + {8'b0, comp, 1'b0};
    r.fire  = 1'b1;
    r.code  = V_OK;
    if (mk == MK_SOS) begin
      if (!seen || len < SOS_HDR_LEN || comp == 8'd0 || {1'b0, len} != sos_len) begin
        r.code = V_INVALID;
      end
    end else if (is_frame(mk)) begin
      if (mk != MK_SOF0 || seen || len < SOF_HDR_LEN) begin
        r.code = V_UNSUPPORTED;
      end else if (prec != BASE_PREC || comp == 8'd0 || {1'b0, len} != sof_len) begin
        r.code = V_INVALID;
      end else if (w != ew || h != eh) begin
        r.code = V_SIZE;
      end else begin
        r.fire = 1'b0;
      end
    end else begin
      r.fire = 1'b0;
    end
    return r;
  endfunction

  assign cnt_inc  = {1'b0, cnt_r} + 17'd1;
  assign len_full = {size_r[15:8], data_byte};

  // byte step
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    size_nxt   = size_r;
    marker_nxt = marker_r;
    seen_nxt   = seen_r;
    prec_nxt   = prec_r;
    height_nxt = height_r;
    width_nxt  = width_r;
    comp_nxt   = comp_r;
    given_nxt  = given_r;
    step_res   = '{fire: 1'b0, code: V_OK};
    jres       = '{fire: 1'b0, code: V_OK};

    if (!given_r) begin
      case (phase_r)
        PH_SOI0: begin
          if (data_byte != MK_PREFIX) step_res = '{fire: 1'b1, code: V_INVALID};
          else phase_nxt = PH_SOI1;
        end
        PH_SOI1: begin
          if (data_byte != MK_SOI) step_res = '{fire: 1'b1, code: V_INVALID};
          else phase_nxt = PH_MARK;
        end
        PH_MARK: begin
          if (data_byte != MK_PREFIX) step_res = '{fire: 1'b1, code: V_INVALID};
          else phase_nxt = PH_FILL;
        end
        PH_FILL: begin
          if (data_byte == MK_PREFIX) begin
            phase_nxt = PH_FILL;
          end else if (data_byte == MK_STUFF || data_byte == MK_TEM ||
                       data_byte == MK_SOI || data_byte == MK_EOI ||
                       data_byte inside {[MK_RST_LO:MK_RST_HI]}) begin
            step_res = '{fire: 1'b1, code: V_INVALID};
          end else begin
            marker_nxt = data_byte;
            prec_nxt   = 8'd0;
            height_nxt = 16'd0;
            width_nxt  = 16'd0;
            comp_nxt   = 8'd0;
            phase_nxt  = PH_LENH;
          end
        end
        PH_LENH: begin
          size_nxt  = {data_byte, 8'h00};
          phase_nxt = PH_LENL;
        end
        PH_LENL: begin
          size_nxt = len_full;
          if (len_full < MIN_SEG_LEN) begin
            step_res = '{fire: 1'b1, code: V_INVALID};
          end else begin
            cnt_nxt = MIN_SEG_LEN;
            if (len_full == MIN_SEG_LEN) begin
              jres = judge(marker_r, len_full, seen_r, prec_r, height_r, width_r,
                           comp_r, exp_width, exp_height);
              step_res = jres;
              if (!jres.fire) begin
                phase_nxt = PH_MARK;
                if (is_frame(marker_r)) seen_nxt = 1'b1;
              end
            end else begin
              phase_nxt = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          // capture header fields of scan and frame segments
          if (marker_r == MK_SOS) begin
            if (cnt_r == 16'd2) comp_nxt = data_byte;
          end else if (is_frame(marker_r)) begin
            case (cnt_r)
              16'd2:   prec_nxt   = data_byte;
              16'd3:   height_nxt = {data_byte, 8'h00};
              16'd4:   height_nxt = {height_r[15:8], data_byte};
              16'd5:   width_nxt  = {data_byte, 8'h00};
              16'd6:   width_nxt  = {width_r[15:8], data_byte};
              16'd7:   comp_nxt   = data_byte;
              default: comp_nxt   = comp_r;
            endcase
          end
          if (cnt_inc >= {1'b0, size_r}) begin
            jres = judge(marker_r, size_r, seen_r, prec_nxt, height_nxt, width_nxt,
                         comp_nxt, exp_width, exp_height);
            step_res = jres;
            if (!jres.fire) begin
              phase_nxt = PH_MARK;
              if (is_frame(marker_r)) seen_nxt = 1'b1;
            end
          end else begin
            cnt_nxt = cnt_inc[15:0];
          end
        end
        default: step_res = '{fire: 1'b1, code: V_INVALID};
      endcase

      // buffer ended without a verdict
      if (!step_res.fire && last_byte) step_res = '{fire: 1'b1, code: V_INVALID};
    end

    // end of buffer: back to the start, otherwise hold off until it comes
    if (last_byte) begin
      phase_nxt  = PH_SOI0;
      cnt_nxt    = 16'd0;
      size_nxt   = 16'd0;
      marker_nxt = 8'd0;
      seen_nxt   = 1'b0;
      prec_nxt   = 8'd0;
      height_nxt = 16'd0;
      width_nxt  = 16'd0;
      comp_nxt   = 8'd0;
      given_nxt  = 1'b0;
    end else if (step_res.fire) begin
      given_nxt = 1'b1;
    end
  end

  assign result = step_res;

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SOI0;
      cnt_r    <= 16'd0;
      size_r   <= 16'd0;
      marker_r <= 8'd0;
      seen_r   <= 1'b0;
      prec_r   <= 8'd0;
      height_r <= 16'd0;
      width_r  <= 16'd0;
      comp_r   <= 8'd0;
      given_r  <= 1'b0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      size_r   <= size_nxt;
      marker_r <= marker_nxt;
      seen_r   <= seen_nxt;
      prec_r   <= prec_nxt;
      height_r <= height_nxt;
      width_r  <= width_nxt;
      comp_r   <= comp_nxt;
      given_r  <= given_nxt;
    end
  end

endmodule

### src/jmsv_out_reg.sv
// ----------------------------------------------------------------------------
// jmsv_out_reg
// Result register on the verdict channel; frees up as the receiver takes it.
// ----------------------------------------------------------------------------
module jmsv_out_reg (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  jmsv_pkg::verdict_t      verdict,
  output logic                    space,
  jmsv_verdict_if.source          out_ch
);
  import jmsv_pkg::*;

  logic       valid_r, valid_nxt;
  verdict_t   verdict_r;

  // slot is free when empty or when the held verdict transfers this cycle
  assign space = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) valid_nxt = 1'b1;
    else if (out_ch.ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) verdict_r <= verdict;
  end

  assign out_ch.valid   = valid_r;
  assign out_ch.verdict = verdict_r;

endmodule

### src/jpeg_marker_stream_validator_unit.sv
// ----------------------------------------------------------------------------
// jpeg_marker_stream_validator_unit
// Checks a JPEG buffer's marker structure and baseline frame header.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one buffer byte per transfer, with last_byte set on the final
//   byte. Each buffer gives exactly one verdict on out_ch: ok at the first
//   valid start-of-scan, otherwise invalid, unsupported frame type or wrong
//   frame size. Bytes after the verdict are absorbed up to the final byte.
//   A verdict appears on out_ch in the cycle after the byte that decides it.
//   One byte is taken every cycle unless a waiting verdict blocks in_ch; the step
//   logic works on each byte as it transfers and writes the verdict register.
//   If the receiver stalls with a verdict held, in_ch.ready drops only while
//   that verdict is still waiting; it rises again in the cycle it transfers.
//   cfg_we with cfg_index selects expected width (0) or height (1); write
//   only while no buffer is in flight.
//   Reset (rst_n low, synchronous) restores width 800 and height 480, empties
//   the verdict register and returns the parser to expect start-of-image.
// ----------------------------------------------------------------------------
module jpeg_marker_stream_validator_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  jmsv_byte_if.sink                          in_ch,
  jmsv_verdict_if.source                     out_ch,
  input  logic                               cfg_we,
  input  logic [jmsv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jmsv_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import jmsv_pkg::*;

  logic [15:0]  exp_width_r;
  logic [15:0]  exp_height_r;
  logic         space;
  logic         in_fire;
  jmsv_result_t result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_width_r  <= RST_EXP_WIDTH;
      exp_height_r <= RST_EXP_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXP_WIDTH:  exp_width_r  <= cfg_wdata;
        CFG_EXP_HEIGHT: exp_height_r <= cfg_wdata;
        default:        exp_width_r  <= exp_width_r;
      endcase
    end
  end

  assign in_ch.ready = space;
  assign in_fire     = in_ch.valid && space;

  jmsv_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .data_byte  (in_ch.data_byte),
    .last_byte  (in_ch.last_byte),
    .exp_width  (exp_width_r),
    .exp_height (exp_height_r),
    .result     (result)
  );

  jmsv_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (in_fire && result.fire),
    .verdict (result.code),
    .space   (space),
    .out_ch  (out_ch)
  );

endmodule

### verif/jpeg_marker_stream_validator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_marker_stream_validator_unit_tb
// Self-checking bench for the JPEG marker stream validator. Whole buffers go
// in byte by byte; a behavioural parser running alongside predicts the
// verdict of each buffer, and every verdict transfer is compared with it.
// Directed buffers hit each marker and header rule, then several frame size
// settings, then random well-formed, broken and noise buffers.
// ----------------------------------------------------------------------------
module jpeg_marker_stream_validator_unit_tb;
  import jmsv_pkg::*;

  localparam int unsigned RUN_LIMIT    = 400000;
  localparam int unsigned TARGET_BYTES = 1300;
  localparam int unsigned TAIL_CYCLES  = 8;

  // marker codes the package leaves out
  localparam logic [7:0] MK_SOF1     = 8'hc1;
  localparam logic [7:0] MK_DHT      = 8'hc4;
  localparam logic [7:0] MK_JPG      = 8'hc8;
  localparam logic [7:0] MK_DAC      = 8'hcc;
  localparam logic [7:0] MK_SOF_LAST = 8'hcf;
  localparam logic [7:0] MK_DQT      = 8'hdb;
  localparam logic [7:0] MK_APP0     = 8'he0;
  localparam logic [7:0] MK_COM      = 8'hfe;

  typedef enum logic [3:0] {
    ST_SOI_FF, ST_SOI_CODE, ST_MARK, ST_FILL, ST_LEN_HI, ST_LEN_LO, ST_BODY
  } parse_state_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  jmsv_byte_if    byte_ch ();
  jmsv_verdict_if verdict_ch ();

  jpeg_marker_stream_validator_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (byte_ch),
    .out_ch    (verdict_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // parser state of the predictor
  parse_state_t ps_state;
  logic [15:0]  ps_idx;
  logic [15:0]  ps_len;
  logic [7:0]   ps_marker;
  bit           ps_sof_done;
  logic [7:0]   ps_prec;
  logic [15:0]  ps_height;
  logic [15:0]  ps_width;
  logic [7:0]   ps_ncomp;
  bit           ps_answered;
  logic [15:0]  want_width;
  logic [15:0]  want_height;

  verdict_t    pending_verdicts[$];
  verdict_t    head_verdict;
  logic [7:0]  buf_bytes[$];
  logic [7:0]  seg_body[$];
  int          errors;
  int          bytes_sent;
  int          buffers_sent;
  int          verdicts_seen;
  int          verdict_tally[4];
  int          size_settings;
  int          cycle_count;
  bit          src_gaps;
  bit          sink_stalls;

  // clock
  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic bit is_frame_marker(input logic [7:0] m);
    return m >= MK_SOF0 && m <= MK_SOF_LAST && m != MK_DHT && m != MK_JPG && m != MK_DAC;
  endfunction

  function automatic bit is_forbidden_code(input logic [7:0] m);
    return m == MK_STUFF || m == MK_TEM || m == MK_SOI || m == MK_EOI ||
           (m >= MK_RST_LO && m <= MK_RST_HI);
  endfunction

  task automatic clear_parser();
    ps_state    = ST_SOI_FF;
    ps_idx      = '0;
    ps_len      = '0;
    ps_marker   = '0;
    ps_sof_done = 1'b0;
    ps_prec     = '0;
    ps_height   = '0;
    ps_width    = '0;
    ps_ncomp    = '0;
    ps_answered = 1'b0;
  endtask

  // judge a segment once its last byte is in
  task automatic close_segment(output bit fired, output verdict_t v);
    int len_i;
    int n_i;
    len_i = ps_len;
    n_i   = ps_ncomp;
    fired = 1'b1;
    v     = V_OK;
    if (ps_marker == MK_SOS) begin
      if (!ps_sof_done || len_i < SOS_HDR_LEN || n_i == 0 || len_i != 6 + 2 * n_i)
        v = V_INVALID;
    end else if (is_frame_marker(ps_marker) &&
                 (ps_marker != MK_SOF0 || ps_sof_done || len_i < SOF_HDR_LEN)) begin
      v = V_UNSUPPORTED;
    end else if (is_frame_marker(ps_marker) &&
                 (ps_prec != BASE_PREC || n_i == 0 || len_i != 8 + 3 * n_i)) begin
      v = V_INVALID;
    end else if (is_frame_marker(ps_marker) &&
                 (ps_width != want_width || ps_height != want_height)) begin
      v = V_SIZE;
    end else begin
      if (is_frame_marker(ps_marker)) ps_sof_done = 1'b1;
      ps_state = ST_MARK;
      fired    = 1'b0;
    end
  endtask

  task automatic step_parser(input logic [7:0] b, output bit fired, output verdict_t v);
    int idx_i;
    idx_i = ps_idx;
    fired = 1'b0;
    v     = V_INVALID;
    case (ps_state)
      ST_SOI_FF: begin
        if (b != MK_PREFIX) fired = 1'b1;
        else ps_state = ST_SOI_CODE;
      end
      ST_SOI_CODE: begin
        if (b != MK_SOI) fired = 1'b1;
        else ps_state = ST_MARK;
      end
      ST_MARK: begin
        if (b != MK_PREFIX) fired = 1'b1;
        else ps_state = ST_FILL;
      end
      ST_FILL: begin
        // further prefix bytes are fill
        if (b != MK_PREFIX) begin
          if (is_forbidden_code(b)) begin
            fired = 1'b1;
          end else begin
            ps_marker = b;
            ps_prec   = '0;
            ps_height = '0;
            ps_width  = '0;
            ps_ncomp  = '0;
            ps_state  = ST_LEN_HI;
          end
        end
      end
      ST_LEN_HI: begin
        ps_len   = {b, 8'h00};
        ps_state = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        ps_len = ps_len | {8'h00, b};
        if (ps_len < MIN_SEG_LEN) begin
          fired = 1'b1;
        end else begin
          ps_idx = 16'd2;
          if (ps_len == MIN_SEG_LEN) close_segment(fired, v);
          else ps_state = ST_BODY;
        end
      end
      ST_BODY: begin
        // header fields sit at fixed offsets, length bytes being 0 and 1
        if (ps_marker == MK_SOS) begin
          if (idx_i == 2) ps_ncomp = b;
        end else if (is_frame_marker(ps_marker)) begin
          case (idx_i)
            2: ps_prec = b;
            3: ps_height = {b, 8'h00};
            4: ps_height = ps_height | {8'h00, b};
            5: ps_width = {b, 8'h00};
            6: ps_width = ps_width | {8'h00, b};
            7: ps_ncomp = b;
            default: ;
          endcase
        end
        if (idx_i + 1 >= ps_len) close_segment(fired, v);
        else ps_idx = ps_idx + 16'd1;
      end
      default: fired = 1'b1;
    endcase
  endtask

  // expected verdict, if any, of one accepted byte
  task automatic predict_verdict(input logic [7:0] b, input logic is_last);
    bit       fired;
    verdict_t v;
    fired = 1'b0;
    v     = V_INVALID;
    if (!ps_answered) begin
      step_parser(b, fired, v);
      if (!fired && is_last) begin
        fired = 1'b1;
        v     = V_INVALID;
      end
      if (fired && !is_last) ps_answered = 1'b1;
      if (fired) pending_verdicts.push_back(v);
    end
    if (is_last) clear_parser();
  endtask

  // ---------------------------------------------------------------- checking

  // verdict receiver with random back-pressure
  always @(posedge clk) begin
    verdict_ch.ready <= !sink_stalls || ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    if (rst_n && verdict_ch.valid && verdict_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t ns: verdict transfer with none expected, actual %0d",
                 $time, verdict_ch.verdict);
      end else begin
        head_verdict = pending_verdicts.pop_front();
        verdicts_seen++;
        verdict_tally[int'(head_verdict)]++;
        if (verdict_ch.verdict !== head_verdict) begin
          errors++;
          $display("%0t ns: verdict mismatch, expected %0d (%s), actual %0d",
                   $time, head_verdict, head_verdict.name(), verdict_ch.verdict);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("%0t ns: run limit of %0d cycles reached, %0d verdicts outstanding",
               $time, RUN_LIMIT, pending_verdicts.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    if (src_gaps && $urandom_range(99) < 30) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= is_last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    predict_verdict(b, is_last);
    bytes_sent++;
  endtask

  // send the assembled buffer, last flag on its final byte
  task automatic send_buffer(input int pause_at);
    for (int k = 0; k < buf_bytes.size(); k++) begin
      if (k == pause_at) hold_until_drained();
      send_byte(buf_bytes[k], k == buf_bytes.size() - 1);
    end
    buffers_sent++;
    buf_bytes.delete();
  endtask

  task automatic hold_until_drained();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // idle the stream and let the last byte work its way through
  task automatic settle();
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame_size(input logic [15:0] w, input logic [15:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_EXP_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_EXP_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we      <= 1'b0;
    want_width  = w;
    want_height = h;
    size_settings++;
  endtask

  // ---------------------------------------------------------------- buffer builders

  task automatic put_soi();
    buf_bytes.push_back(MK_PREFIX);
    buf_bytes.push_back(MK_SOI);
  endtask

  task automatic put_marker(input logic [7:0] code, input int fill);
    buf_bytes.push_back(MK_PREFIX);
    repeat (fill) buf_bytes.push_back(MK_PREFIX);
    buf_bytes.push_back(code);
  endtask

  // body comes from seg_body, padded with random bytes, cut at max_body
  task automatic put_segment(input logic [7:0] code, input logic [15:0] seg_len,
                             input int fill, input int max_body);
    int body_n;
    body_n = seg_len;
    body_n = body_n - 2;
    put_marker(code, fill);
    buf_bytes.push_back(seg_len[15:8]);
    buf_bytes.push_back(seg_len[7:0]);
    for (int k = 0; k < body_n && k < max_body; k++)
      buf_bytes.push_back(k < seg_body.size() ? seg_body[k] : rand_byte());
    seg_body.delete();
  endtask

  task automatic put_sof(input logic [7:0] code, input logic [7:0] prec,
                         input logic [15:0] h, input logic [15:0] w,
                         input logic [7:0] n, input logic [15:0] seg_len, input int fill);
    seg_body.push_back(prec);
    seg_body.push_back(h[15:8]);
    seg_body.push_back(h[7:0]);
    seg_body.push_back(w[15:8]);
    seg_body.push_back(w[7:0]);
    seg_body.push_back(n);
    put_segment(code, seg_len, fill, 65535);
  endtask

  task automatic put_sos(input logic [7:0] n, input logic [15:0] seg_len, input int fill);
    seg_body.push_back(n);
    put_segment(MK_SOS, seg_len, fill, 65535);
  endtask

  task automatic put_good_image(input int n, input logic [15:0] w, input logic [15:0] h);
    put_soi();
    put_sof(MK_SOF0, BASE_PREC, h, w, 8'(n), 16'(8 + 3 * n), 0);
    put_sos(8'(n), 16'(6 + 2 * n), 0);
    repeat ($urandom_range(4)) buf_bytes.push_back(rand_byte());
  endtask

  function automatic int fill_count();
    return ($urandom_range(99) < 20) ? $urandom_range(3, 1) : 0;
  endfunction

  function automatic logic [7:0] misc_code();
    case ($urandom_range(3))
      0: return 8'(MK_APP0 + $urandom_range(15));
      1: return MK_DQT;
      2: return MK_DHT;
      default: return MK_COM;
    endcase
  endfunction

  function automatic logic [7:0] random_frame_code();
    logic [7:0] c;
    do c = 8'(MK_SOF0 + $urandom_range(15)); while (!is_frame_marker(c));
    return c;
  endfunction

  task automatic put_misc_segments(input int count);
    repeat (count)
      put_segment(misc_code(), 16'($urandom_range(12, 2)), fill_count(), 65535);
  endtask

  task automatic build_random_buffer();
    int         kind;
    int         n;
    int         n_scan;
    int         sof_len;
    int         sos_len;
    int         cut;
    logic [15:0] w;
    logic [15:0] h;
    logic [7:0]  code;
    logic [7:0]  prec;
    kind = $urandom_range(99);
    if (kind < 80) begin
      // image with random content, broken now and then
      n = $urandom_range(4, 1);
      n_scan = ($urandom_range(99) < 4) ? 0 : n;
      w = want_width;
      h = want_height;
      if ($urandom_range(99) < 12) begin
        if ($urandom_range(1)) w = w ^ (16'h0001 << $urandom_range(15));
        else h = h ^ (16'h0001 << $urandom_range(15));
      end
      code = ($urandom_range(99) < 6) ? random_frame_code() : MK_SOF0;
      prec = ($urandom_range(99) < 5) ? rand_byte() : BASE_PREC;
      sof_len = 8 + 3 * n;
      sos_len = 6 + 2 * n_scan;
      if ($urandom_range(99) < 6) sof_len = sof_len + $urandom_range(2) - 1;
      if ($urandom_range(99) < 6) sos_len = sos_len + $urandom_range(2) - 1;
      put_soi();
      put_misc_segments($urandom_range(2));
      put_sof(code, prec, h, w, 8'(n), 16'(sof_len), fill_count());
      if ($urandom_range(99) < 3)
        put_sof(MK_SOF0, BASE_PREC, h, w, 8'(n), 16'(8 + 3 * n), 0);
      put_misc_segments($urandom_range(1));
      put_sos(8'(n_scan), 16'(sos_len), fill_count());
      repeat ($urandom_range(8)) buf_bytes.push_back(rand_byte());
      if (kind >= 60) begin
        if ($urandom_range(1)) begin
          buf_bytes[$urandom_range(buf_bytes.size() - 1)] = rand_byte();
        end else begin
          cut = $urandom_range(buf_bytes.size(), 1);
          while (buf_bytes.size() > cut) void'(buf_bytes.pop_back());
        end
      end
    end else if (kind < 92) begin
      // plain noise, sometimes behind a valid start-of-image
      if ($urandom_range(1)) put_soi();
      repeat ($urandom_range(12, 1)) buf_bytes.push_back(rand_byte());
    end else begin
      // any segment length, body cut short
      put_soi();
      put_segment(misc_code(), {rand_byte(), rand_byte()}, fill_count(),
                  $urandom_range(40));
    end
  endtask

  // ---------------------------------------------------------------- tests

  // every marker and header rule once, at the reset frame size
  task automatic test_directed_cases();
    logic [7:0] bad_codes[6];
    bad_codes = '{MK_STUFF, MK_TEM, MK_RST_LO, MK_RST_HI, MK_SOI, MK_EOI};
    // start-of-image checks, lone bytes at both extremes
    buf_bytes.push_back(MK_STUFF);
    send_buffer(-1);
    buf_bytes.push_back(MK_PREFIX);
    send_buffer(-1);
    buf_bytes = '{MK_PREFIX, MK_STUFF, 8'h55, 8'haa};
    send_buffer(-1);
    put_soi();
    buf_bytes.push_back(8'h7f);
    buf_bytes.push_back(MK_PREFIX);
    send_buffer(-1);
    // standalone and restart markers after fill
    foreach (bad_codes[i]) begin
      put_soi();
      put_marker(bad_codes[i], 1);
      buf_bytes.push_back(MK_PREFIX);
      send_buffer(-1);
    end
    // length below two, then an empty segment ending the buffer
    put_soi();
    put_marker(MK_APP0, 0);
    buf_bytes.push_back(8'h00);
    buf_bytes.push_back(8'h01);
    buf_bytes.push_back(8'h00);
    send_buffer(-1);
    put_soi();
    put_segment(MK_APP0, MIN_SEG_LEN, 0, 65535);
    send_buffer(-1);
    // marker at the very end
    put_soi();
    put_marker(MK_COM, 2);
    send_buffer(-1);
    // clean image with fill bytes and a table segment
    put_soi();
    put_segment(MK_DQT, 5, 3, 65535);
    put_sof(MK_SOF0, BASE_PREC, want_height, want_width, 1, 11, 1);
    put_sos(1, 8, 2);
    buf_bytes.push_back(MK_PREFIX);
    buf_bytes.push_back(MK_STUFF);
    send_buffer(-1);
    // frame type rejected: other SOF, short SOF0, second SOF0
    put_soi();
    put_sof(MK_SOF1, BASE_PREC, want_height, want_width, 1, 11, 0);
    send_buffer(-1);
    put_soi();
    put_sof(MK_SOF0, BASE_PREC, want_height, want_width, 1, 7, 0);
    send_buffer(-1);
    put_soi();
    put_sof(MK_SOF0, BASE_PREC, want_height, want_width, 1, 11, 0);
    put_sof(MK_SOF0, BASE_PREC, want_height, want_width, 1, 11, 0);
    send_buffer(-1);
    // bad SOF0 contents: precision, no components, length off
    put_soi();
    put_sof(MK_SOF0, 8'd12, want_height, want_width, 1, 11, 0);
    send_buffer(-1);
    put_soi();
    put_sof(MK_SOF0, BASE_PREC, want_height, want_width, 0, 8, 0);
    send_buffer(-1);
    put_soi();
    put_sof(MK_SOF0, BASE_PREC, want_height, want_width, 2, 15, 0);
    send_buffer(-1);
    // wrong width, wrong height
    put_good_image(3, want_width + 16'd1, want_height);
    send_buffer(-1);
    put_good_image(3, want_width, want_height - 16'd1);
    send_buffer(-1);
    // scan header: before any frame, too short, no components, length off
    put_soi();
    put_sos(1, 8, 0);
    send_buffer(-1);
    put_soi();
    put_sof(MK_SOF0, BASE_PREC, want_height, want_width, 1, 11, 0);
    put_sos(1, 5, 0);
    send_buffer(-1);
    put_soi();
    put_sof(MK_SOF0, BASE_PREC, want_height, want_width, 1, 11, 0);
    put_sos(0, 6, 0);
    send_buffer(-1);
    put_soi();
    put_sof(MK_SOF0, BASE_PREC, want_height, want_width, 1, 11, 0);
    put_sos(1, 9, 0);
    send_buffer(-1);
    settle();
  endtask

  // frame size registers at their extremes and at random
  task automatic test_frame_size_registers();
    logic [15:0] w;
    logic [15:0] h;
    for (int s = 0; s < 4; s++) begin
      case (s)
        0: begin w = 16'h0000; h = 16'h0000; end
        1: begin w = 16'hffff; h = 16'hffff; end
        2: begin w = 16'h0001; h = 16'hfffe; end
        default: begin w = 16'($urandom); h = 16'($urandom); end
      endcase
      settle();
      set_frame_size(w, h);
      put_good_image(s + 1, w, h);
      send_buffer(-1);
      put_good_image(2, w ^ 16'h8000, h);
      send_buffer(-1);
      put_good_image(4, w, h ^ 16'h0001);
      send_buffer(-1);
    end
    settle();
  endtask

  // random buffers in four phases; the second runs with no idling at all
  task automatic test_random_streams();
    int  byte_goal;
    int  budget;
    bit  paused;
    paused = 1'b0;
    // the rest of the byte target is shared between the phases
    budget = int'(TARGET_BYTES) - bytes_sent;
    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        1: set_frame_size(16'hffff, 16'h0000);
        2: set_frame_size(RST_EXP_WIDTH, RST_EXP_HEIGHT);
        default: set_frame_size(16'($urandom), 16'($urandom));
      endcase
      src_gaps    = (p != 1);
      sink_stalls = (p != 1);
      byte_goal   = bytes_sent + budget / 4;
      while (bytes_sent < byte_goal) begin
        build_random_buffer();
        // once, stop mid-buffer until every verdict is in
        if (p == 2 && !paused && buf_bytes.size() > 4) begin
          paused = 1'b1;
          send_buffer(buf_bytes.size() / 2);
        end else begin
          send_buffer(-1);
        end
      end
    end
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    settle();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= '0;
    byte_ch.last_byte <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_EXP_WIDTH;
    cfg_wdata         <= '0;
    rst_n             <= 1'b0;
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    want_width  = RST_EXP_WIDTH;
    want_height = RST_EXP_HEIGHT;
    clear_parser();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_frame_size_registers();
    test_random_streams();

    $display("Sent %0d buffers (%0d bytes) over %0d frame size settings after reset",
             buffers_sent, bytes_sent, size_settings);
    $display("Verdicts checked: %0d ok, %0d invalid, %0d unsupported, %0d wrong size",
             verdict_tally[V_OK], verdict_tally[V_INVALID], verdict_tally[V_UNSUPPORTED],
             verdict_tally[V_SIZE]);
    if (errors == 0 && verdicts_seen == buffers_sent) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
src/jmsv_pkg.sv
src/jmsv_if.sv
src/jmsv_parser.sv
src/jmsv_out_reg.sv
src/jpeg_marker_stream_validator_unit.sv
verif/jpeg_marker_stream_validator_unit_tb.sv
